FILE: hw/rtl/aenc_pkg.sv
package aenc_pkg;

  localparam int CODE_BITS_DEF = 32;
  localparam int CUM_LOW_W     = 30;
  localparam int CUM_W         = 31;
  localparam int PEND_W        = 32;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_RENORM,
    ST_FLUSH,
    ST_FINISH
  } enc_state_t;

  typedef enum logic [1:0] {
    RN_EMIT0,
    RN_EMIT1,
    RN_GROW,
    RN_STOP
  } renorm_kind_t;

endpackage

FILE: hw/rtl/aenc_muldiv.sv
// Serial scale unit: quot = span * mult / divisor.
// Shift-add multiply one multiplier bit per cycle, then restoring divide
// one quotient bit per cycle, reusing the product register for the quotient.
module aenc_muldiv #(
  parameter int CODE_BITS = aenc_pkg::CODE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CODE_BITS:0]     span,
  input  logic [aenc_pkg::CUM_W-1:0] mult,
  input  logic [aenc_pkg::CUM_W-1:0] divisor,
  output logic                   done,
  output logic [CODE_BITS:0]     quot
);

  localparam int MW = aenc_pkg::CUM_W;
  localparam int PW = CODE_BITS + 1 + MW;
  localparam int CW = $clog2(PW);

  aenc_pkg::md_phase_t phase, phase_next;

  logic [CW-1:0]      cnt;
  logic [PW-1:0]      acc;
  logic [MW-1:0]      mreg;
  logic [CODE_BITS:0] sreg;
  logic [MW-1:0]      dreg;
  logic [MW-1:0]      rem;

  logic [PW-1:0] acc_add;
  logic [MW:0]   rshift;
  logic [MW:0]   rdiff;
  logic          fits;

  assign acc_add = {acc[PW-2:0], 1'b0} + (mreg[MW-1] ? PW'(sreg) : '0);
  assign rshift  = {rem, acc[PW-1]};
  assign fits    = rshift >= {1'b0, dreg};
  assign rdiff   = rshift - {1'b0, dreg};
  assign quot    = acc[CODE_BITS:0];

  always_comb begin
    phase_next = phase;
    unique case (phase)
      aenc_pkg::MD_IDLE: if (start) phase_next = aenc_pkg::MD_MUL;
      aenc_pkg::MD_MUL:  if (cnt == '0) phase_next = aenc_pkg::MD_DIV;
      aenc_pkg::MD_DIV:  if (cnt == '0) phase_next = aenc_pkg::MD_IDLE;
      default:           phase_next = aenc_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= aenc_pkg::MD_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == aenc_pkg::MD_DIV) && (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      aenc_pkg::MD_IDLE: begin
        if (start) begin
          sreg <= span;
          mreg <= mult;
          dreg <= divisor;
          acc  <= '0;
          rem  <= '0;
          cnt  <= CW'(MW - 1);
        end
      end
      aenc_pkg::MD_MUL: begin
        acc  <= acc_add;
        mreg <= {mreg[MW-2:0], 1'b0};
        cnt  <= (cnt == '0) ? CW'(PW - 1) : cnt - 1'b1;
      end
      aenc_pkg::MD_DIV: begin
        acc <= {acc[PW-2:0], fits};
        rem <= fits ? rdiff[MW-1:0] : rshift[MW-1:0];
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/arithmetic_encoder_unit.sv
// Sequence: an encode item is scaled by two bit-serial units (31 multiply steps, CODE_BITS+32
//   divide steps), then renormalizes one step at a time, stalling while a held result cannot
//   leave; its last result leaves from ST_FLUSH. A finish item yields a single last result.
// Flow: one item at a time; in_ready stays low until the unit returns to ST_IDLE.
// Reset (rst, synchronous): interval low 0, high all ones, pending count 0.
module arithmetic_encoder_unit #(
  parameter int CODE_BITS = aenc_pkg::CODE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [aenc_pkg::CUM_LOW_W-1:0]   cum_low,
  input  logic [aenc_pkg::CUM_W-1:0]       cum_high,
  input  logic [aenc_pkg::CUM_W-1:0]       total,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             bit_res,
  output logic [aenc_pkg::PEND_W-1:0]      follow_count,
  output logic                             last
);

  localparam int PEND_W = aenc_pkg::PEND_W;

  aenc_pkg::enc_state_t   state, state_next;
  aenc_pkg::renorm_kind_t kind;

  logic [CODE_BITS-1:0] low;
  logic [CODE_BITS-1:0] high;
  logic [PEND_W-1:0]    pend;
  logic [PEND_W-1:0]    pend_inc;

  // one result held back until we know whether it is the last of its item
  logic                 hv;
  logic                 hbit;
  logic [PEND_W-1:0]    hcnt;

  logic                 accept;
  logic                 sym_bad;
  logic                 md_start;
  logic                 out_free;
  logic                 out_load;
  logic                 emit_ok;
  logic                 is_emit;
  logic                 done_hi, done_lo;
  logic [CODE_BITS:0]   span;
  logic [CODE_BITS:0]   q_hi, q_lo;
  logic [CODE_BITS:0]   new_high, new_low;

  assign accept   = in_valid && in_ready;
  assign sym_bad  = (total == '0) || (cum_high > total) ||
                    ({1'b0, cum_low} >= cum_high);
  assign span     = {1'b0, high} - {1'b0, low} + 1'b1;
  assign pend_inc = (pend == '1) ? pend : pend + 1'b1;
  assign out_free = !out_valid || out_ready;
  assign emit_ok  = !hv || out_free;
  assign is_emit  = (kind == aenc_pkg::RN_EMIT0) || (kind == aenc_pkg::RN_EMIT1);
  assign new_high = {1'b0, low} + q_hi - 1'b1;
  assign new_low  = {1'b0, low} + q_lo;
  assign out_load = ((state == aenc_pkg::ST_RENORM) && is_emit && emit_ok && hv) ||
                    (((state == aenc_pkg::ST_FLUSH) || (state == aenc_pkg::ST_FINISH)) &&
                     out_free);

  aenc_muldiv #(.CODE_BITS(CODE_BITS)) u_md_hi (
    .clk     (clk),
    .rst     (rst),
    .start   (md_start),
    .span    (span),
    .mult    (cum_high),
    .divisor (total),
    .done    (done_hi),
    .quot    (q_hi)
  );

  aenc_muldiv #(.CODE_BITS(CODE_BITS)) u_md_lo (
    .clk     (clk),
    .rst     (rst),
    .start   (md_start),
    .span    (span),
    .mult    (aenc_pkg::CUM_W'(cum_low)),
    .divisor (total),
    .done    (done_lo),
    .quot    (q_lo)
  );

  always_comb begin
    if (!high[CODE_BITS-1])                           kind = aenc_pkg::RN_EMIT0;
    else if (low[CODE_BITS-1])                        kind = aenc_pkg::RN_EMIT1;
    else if (low[CODE_BITS-2] && !high[CODE_BITS-2])  kind = aenc_pkg::RN_GROW;
    else                                              kind = aenc_pkg::RN_STOP;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aenc_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == aenc_pkg::OP_FINISH) state_next = aenc_pkg::ST_FINISH;
          else if (!sym_bad)             state_next = aenc_pkg::ST_CALC;
        end
      end
      aenc_pkg::ST_CALC: begin
        if (done_hi && done_lo) begin
          state_next = (q_hi <= q_lo) ? aenc_pkg::ST_IDLE : aenc_pkg::ST_RENORM;
        end
      end
      aenc_pkg::ST_RENORM: begin
        if (kind == aenc_pkg::RN_STOP) begin
          state_next = hv ? aenc_pkg::ST_FLUSH : aenc_pkg::ST_IDLE;
        end
      end
      aenc_pkg::ST_FLUSH:  if (out_free) state_next = aenc_pkg::ST_IDLE;
      aenc_pkg::ST_FINISH: if (out_free) state_next = aenc_pkg::ST_IDLE;
      default:             state_next = aenc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == aenc_pkg::ST_IDLE);
    md_start = accept && (op == aenc_pkg::OP_ENCODE) && !sym_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aenc_pkg::ST_IDLE;
      low       <= '0;
      high      <= '1;
      pend      <= '0;
      hv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        aenc_pkg::ST_CALC: begin
          if (done_hi && done_lo && (q_hi > q_lo)) begin
            high <= new_high[CODE_BITS-1:0];
            low  <= new_low[CODE_BITS-1:0];
          end
        end
        aenc_pkg::ST_RENORM: begin
          if (is_emit && emit_ok) begin
            if (hv) begin
              // an earlier result is now known not to be the last
              bit_res      <= hbit;
              follow_count <= hcnt;
              last         <= 1'b0;
            end
            hv   <= 1'b1;
            hbit <= (kind == aenc_pkg::RN_EMIT1);
            hcnt <= pend;
            pend <= '0;
            low  <= {low[CODE_BITS-2:0], 1'b0};
            high <= {high[CODE_BITS-2:0], 1'b1};
          end else if (kind == aenc_pkg::RN_GROW) begin
            pend <= pend_inc;
            low  <= {1'b0, low[CODE_BITS-3:0], 1'b0};
            high <= {1'b1, high[CODE_BITS-3:0], 1'b1};
          end
        end
        aenc_pkg::ST_FLUSH: begin
          if (out_free) begin
            bit_res      <= hbit;
            follow_count <= hcnt;
            last         <= 1'b1;
            hv           <= 1'b0;
          end
        end
        aenc_pkg::ST_FINISH: begin
          if (out_free) begin
            bit_res      <= (low[CODE_BITS-1:CODE_BITS-2] != 2'b00);
            follow_count <= pend_inc;
            last         <= 1'b1;
            low          <= '0;
            high         <= '1;
            pend         <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/aenc_checker.sv
module aenc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           op,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           bit_res,
  input logic [aenc_pkg::PEND_W-1:0]    follow_count,
  input logic                           last
);

  // a reset leaves nothing on the output
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bit_res) &&
      $stable(follow_count) && $stable(last))
    else $error("stalled result changed");

  // a finish item blocks the input until its closing bit is out
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == aenc_pkg::OP_FINISH) |=> !in_ready)
    else $error("input taken while finish pending");

  // while a non-last result waits, more of the same item are still to come
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input open before last result of item");

endmodule

bind arithmetic_encoder_unit aenc_checker u_aenc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .op           (op),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .bit_res      (bit_res),
  .follow_count (follow_count),
  .last         (last)
);

FILE: tb/sv/arithmetic_encoder_unit_check.sv
module arithmetic_encoder_unit_check #(
  parameter int CODE_BITS = aenc_pkg::CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           op,
  input  logic [aenc_pkg::CUM_LOW_W-1:0] cum_low,
  input  logic [aenc_pkg::CUM_W-1:0]     cum_high,
  input  logic [aenc_pkg::CUM_W-1:0]     total,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           bit_res,
  input  logic [aenc_pkg::PEND_W-1:0]    follow_count,
  input  logic                           last,
  output int                             errors,
  output int                             waiting,
  output int                             items_taken,
  output int                             bits_taken,
  output int                             items_dropped
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        bit_res;
    logic [aenc_pkg::PEND_W-1:0] follow;
    logic                        last;
  } code_bit_t;

  localparam logic [63:0] WHOLE   = 64'd1 << CODE_BITS;
  localparam logic [63:0] MASK    = WHOLE - 64'd1;
  localparam logic [63:0] HALF    = WHOLE >> 1;
  localparam logic [63:0] QUARTER = WHOLE >> 2;
  localparam logic [63:0] THREEQ  = HALF + QUARTER;

  code_bit_t                   code_bits_due[$];
  logic [63:0]                 range_low;
  logic [63:0]                 range_high;
  logic [aenc_pkg::PEND_W-1:0] pending_bits;

  task automatic clear_coder();
    range_low    = 64'd0;
    range_high   = MASK;
    pending_bits = '0;
  endtask

  task automatic bump_pending();
    if (pending_bits != '1) pending_bits = pending_bits + 1'b1;
  endtask

  // Narrow the interval and renormalize; queue every code bit this item yields.
  task automatic code_item(input logic op_i, input logic [aenc_pkg::CUM_LOW_W-1:0] cl,
                           input logic [aenc_pkg::CUM_W-1:0] ch,
                           input logic [aenc_pkg::CUM_W-1:0] tot);
    logic [63:0] span;
    logic [63:0] top;
    logic [63:0] bot;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        done;
    code_bit_t   batch[$];
    code_bit_t   cb;
    if (op_i == aenc_pkg::OP_FINISH) begin
      bump_pending();
      cb.bit_res = (range_low < QUARTER) ? 1'b0 : 1'b1;
      cb.follow  = pending_bits;
      cb.last    = 1'b1;
      code_bits_due = {code_bits_due, cb};
      clear_coder();
      return;
    end
    if (tot == '0 || ch > tot || {1'b0, cl} >= ch) begin
      items_dropped++;
      return;
    end
    span = range_high - range_low + 64'd1;
    top  = span * {33'd0, ch} / {33'd0, tot};
    bot  = span * {34'd0, cl} / {33'd0, tot};
    if (top <= bot) begin
      items_dropped++;
      return;
    end
    hi   = range_low + top - 64'd1;
    lo   = range_low + bot;
    done = 1'b0;
    while (!done) begin
      if (hi < HALF) begin
        cb.bit_res = 1'b0;
        cb.follow  = pending_bits;
        cb.last    = 1'b0;
        batch = {batch, cb};
        pending_bits = '0;
      end else if (lo >= HALF) begin
        cb.bit_res = 1'b1;
        cb.follow  = pending_bits;
        cb.last    = 1'b0;
        batch = {batch, cb};
        pending_bits = '0;
        lo = lo - HALF;
        hi = hi - HALF;
      end else if (lo >= QUARTER && hi < THREEQ) begin
        bump_pending();
        lo = lo - QUARTER;
        hi = hi - QUARTER;
      end else begin
        done = 1'b1;
      end
      if (!done) begin
        lo = (lo << 1) & MASK;
        hi = ((hi << 1) | 64'd1) & MASK;
      end
    end
    range_low  = lo;
    range_high = hi;
    foreach (batch[i]) begin
      cb      = batch[i];
      cb.last = (i == batch.size() - 1);
      code_bits_due = {code_bits_due, cb};
    end
  endtask

  always @(posedge clk) begin
    code_bit_t want;
    if (rst) begin
      clear_coder();
      code_bits_due.delete();
      errors        = 0;
      items_taken   = 0;
      bits_taken    = 0;
      items_dropped = 0;
      waiting      <= 0;
    end else begin
      if (in_valid && in_ready) begin
        items_taken++;
        code_item(op, cum_low, cum_high, total);
      end
      if (out_valid && out_ready) begin
        bits_taken++;
        if (code_bits_due.size() == 0) begin
          $display("%0t: unexpected code bit: bit_res %0d follow_count %0d last %0d",
                   $time, bit_res, follow_count, last);
          errors++;
        end else begin
          want = code_bits_due.pop_front();
          if (bit_res !== want.bit_res) begin
            $display("%0t: bit_res expected %0d actual %0d", $time, want.bit_res, bit_res);
            errors++;
          end
          if (follow_count !== want.follow) begin
            $display("%0t: follow_count expected %0d actual %0d",
                     $time, want.follow, follow_count);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, last);
            errors++;
          end
        end
      end
      waiting <= code_bits_due.size();
    end
  end

endmodule

FILE: tb/sv/arithmetic_encoder_unit_test.sv
module arithmetic_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYMBOL_ITEMS = 210;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int unsigned CUM_TOP = 32'd1 << 30;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           op = aenc_pkg::OP_ENCODE;
  logic [aenc_pkg::CUM_LOW_W-1:0] cum_low = '0;
  logic [aenc_pkg::CUM_W-1:0]     cum_high = '0;
  logic [aenc_pkg::CUM_W-1:0]     total = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           bit_res;
  logic [aenc_pkg::PEND_W-1:0]    follow_count;
  logic                           last;

  int errors;
  int waiting;
  int items_taken;
  int bits_taken;
  int items_dropped;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  arithmetic_encoder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .cum_low(cum_low), .cum_high(cum_high), .total(total),
    .out_valid(out_valid), .out_ready(out_ready),
    .bit_res(bit_res), .follow_count(follow_count), .last(last)
  );

  arithmetic_encoder_unit_check check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .cum_low(cum_low), .cum_high(cum_high), .total(total),
    .out_valid(out_valid), .out_ready(out_ready),
    .bit_res(bit_res), .follow_count(follow_count), .last(last),
    .errors(errors), .waiting(waiting), .items_taken(items_taken),
    .bits_taken(bits_taken), .items_dropped(items_dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: short random holds, one long hold on request, none once calm.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready  <= 1'b0;
      stall_left <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(1, 5) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("arithmetic_encoder_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op_i, input int unsigned cl, input int unsigned ch,
                           input int unsigned tot);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_i;
    cum_low  <= cl[aenc_pkg::CUM_LOW_W-1:0];
    cum_high <= ch[aenc_pkg::CUM_W-1:0];
    total    <= tot[aenc_pkg::CUM_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_symbol(input int unsigned cl, input int unsigned ch,
                             input int unsigned tot);
    send_item(aenc_pkg::OP_ENCODE, cl, ch, tot);
  endtask

  // Valid symbol with a random total spread over all magnitudes.
  task automatic send_random_symbol();
    int unsigned tot;
    int unsigned cl;
    int unsigned ch;
    tot = $urandom_range(1, 32'd1 << $urandom_range(0, 30));
    cl  = $urandom_range(0, tot - 1);
    ch  = $urandom_range(cl + 1, tot);
    send_symbol(cl, ch, tot);
  endtask

  // Symbol whose share sits in the middle half, which tends to grow pending bits.
  task automatic send_middle_symbol();
    int unsigned tot;
    tot = $urandom_range(4, 32'd1 << $urandom_range(2, 30));
    send_symbol($urandom_range(tot / 4, tot / 2), $urandom_range(tot / 2 + 1, 3 * tot / 4),
                tot);
  endtask

  task automatic send_malformed();
    int unsigned tot;
    int unsigned ch;
    case ($urandom_range(0, 2))
      0: send_symbol($urandom_range(0, CUM_TOP - 1), $urandom_range(1, CUM_TOP), 0);
      1: begin
        tot = $urandom_range(1, CUM_TOP - 1);
        send_symbol($urandom_range(0, CUM_TOP - 1), $urandom_range(tot + 1, CUM_TOP), tot);
      end
      default: begin
        ch = $urandom_range(1, CUM_TOP - 1);
        send_symbol($urandom_range(ch, CUM_TOP - 1), ch, $urandom_range(ch, CUM_TOP));
      end
    endcase
  endtask

  initial begin
    int good;
    int pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // finish straight out of reset, with every unused field bit set
    send_item(aenc_pkg::OP_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_symbol(0, 1, 1);
    send_symbol(0, 1, CUM_TOP);
    send_symbol(CUM_TOP - 1, CUM_TOP, CUM_TOP);
    send_symbol(0, CUM_TOP, CUM_TOP);
    send_symbol(0, 1, 0);
    send_symbol(0, 5, 4);
    send_symbol(3, 3, 8);
    send_symbol(7, 2, 8);
    repeat (4) send_symbol(1, 3, 4);
    send_item(aenc_pkg::OP_FINISH, 0, 0, 0);
    repeat (3) send_symbol(1, 3, 4);
    send_symbol(0, 1, 4);
    repeat (2) send_symbol(1, 3, 4);
    send_symbol(3, 4, 4);
    send_item(aenc_pkg::OP_FINISH, CUM_TOP - 1, CUM_TOP, CUM_TOP);
    send_symbol(1, 2, 3);
    send_item(aenc_pkg::OP_FINISH, 0, 0, 0);

    good = 0;
    while (good < SYMBOL_ITEMS) begin
      if (good == 80 && !hold_req) hold_req <= 1'b1;
      if (good == SYMBOL_ITEMS - 40 && !calm) calm <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_item(aenc_pkg::OP_FINISH, $urandom, $urandom, $urandom);
        good++;
      end else if (pick < 14) begin
        send_malformed();
      end else if (pick < 32) begin
        send_middle_symbol();
        good++;
      end else begin
        send_random_symbol();
        good++;
      end
    end
    send_item(aenc_pkg::OP_FINISH, 0, 0, 0);
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d malformed and dropped), %0d code bits compared,",
             items_taken, items_dropped, bits_taken);
    $display("with pending-bit runs, finishes and a long output hold that backed up the input");
    if (errors == 0 && waiting == 0) begin
      $display("arithmetic_encoder_unit regression: pass");
    end else begin
      $display("arithmetic_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/aenc_pkg.sv
hw/rtl/aenc_muldiv.sv
hw/rtl/arithmetic_encoder_unit.sv
hw/rtl/aenc_checker.sv
tb/sv/arithmetic_encoder_unit_check.sv
tb/sv/arithmetic_encoder_unit_test.sv
